FILE: rtl/core/dfa_pkg.sv
// Shared types and codes for the table-driven word recognizer.
// Used by dfa_scan, dfa_word_recognizer and dfa_checker; depends on nothing.
package dfa_pkg;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_SYMBOL = 2'd1;
	localparam logic [1:0] OP_END    = 2'd2;

	localparam logic [1:0] CFG_START_STATE = 2'd0;
	localparam logic [1:0] CFG_ACCEPT_MASK = 2'd1;
	localparam logic [1:0] CFG_RULE_COUNT  = 2'd2;

	localparam int STATE_W = 4;
	localparam int SYM_W   = 8;
	localparam int CFG_W   = 16;

	typedef struct packed {
		logic [1:0]         op;
		logic [5:0]         rule_slot;
		logic [STATE_W-1:0] rule_from;
		logic [SYM_W-1:0]   rule_symbol;
		logic [STATE_W-1:0] rule_to;
		logic [SYM_W-1:0]   symbol;
	} cmd_t;

	typedef struct packed {
		logic               accepted;
		logic [STATE_W-1:0] final_state;
	} result_t;

	// One rule table entry: from[15:12], symbol[11:4], to[3:0].
	typedef struct packed {
		logic [STATE_W-1:0] from_state;
		logic [SYM_W-1:0]   symbol;
		logic [STATE_W-1:0] to_state;
	} rule_t;

	typedef struct packed {
		logic               go;
		logic [SYM_W-1:0]   symbol;
		logic [STATE_W-1:0] from_state;
	} scan_req_t;

	typedef struct packed {
		logic               done;
		logic               hit;
		logic [STATE_W-1:0] to_state;
	} scan_rsp_t;

endpackage

FILE: rtl/core/dfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package needed.
module dfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/dfa_scan.sv
// Rule scan sequencer: walks the rule table one entry a cycle and reports the first match.
// Depends on dfa_pkg; drives the read port of a dfa_ram owned by the top level.
module dfa_scan #(
	parameter int AW = 6,
	parameter int CW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dfa_pkg::scan_req_t  req,
	input  logic [CW-1:0]       limit,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	input  dfa_pkg::rule_t      rd_data,
	output dfa_pkg::scan_rsp_t  rsp,
	output logic                busy
);

	typedef enum logic [1:0] {
		SC_IDLE = 2'b01,
		SC_RUN  = 2'b10
	} scan_state_t;

	scan_state_t                 state_q;
	logic [CW-1:0]               issue_q;
	logic                        chk_s1;
	logic [CW-1:0]               limit_q;
	logic [dfa_pkg::SYM_W-1:0]   sym_q;
	logic [dfa_pkg::STATE_W-1:0] from_q;
	dfa_pkg::scan_rsp_t          rsp_q;
	logic                        hit;

	always_comb begin
		rd_en   = (state_q == SC_RUN) && (issue_q < limit_q);
		rd_addr = issue_q[AW-1:0];
		hit     = chk_s1 && (rd_data.from_state == from_q) && (rd_data.symbol == sym_q);
	end

	// latch the request payload
	always_ff @(posedge clk) begin
		if (state_q == SC_IDLE && req.go) begin
			limit_q <= limit;
			sym_q   <= req.symbol;
			from_q  <= req.from_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			issue_q <= '0;
			chk_s1  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			case (state_q)
				SC_IDLE: begin
					if (req.go) begin
						if (limit == '0) begin
							rsp_q.done <= 1'b1;
							rsp_q.hit  <= 1'b0;
						end else begin
							state_q <= SC_RUN;
							issue_q <= '0;
							chk_s1  <= 1'b0;
						end
					end
				end
				SC_RUN: begin
					chk_s1 <= rd_en;
					if (rd_en) begin
						issue_q <= issue_q + CW'(1);
					end
					if (hit) begin
						rsp_q.done     <= 1'b1;
						rsp_q.hit      <= 1'b1;
						rsp_q.to_state <= rd_data.to_state;
						state_q        <= SC_IDLE;
						chk_s1         <= 1'b0;
					end else if (chk_s1 && !rd_en) begin
						// last entry checked without a match
						rsp_q.done <= 1'b1;
						rsp_q.hit  <= 1'b0;
						state_q    <= SC_IDLE;
						chk_s1     <= 1'b0;
					end
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	assign rsp  = rsp_q;
	assign busy = (state_q != SC_IDLE) || rsp_q.done;

endmodule

FILE: rtl/core/dfa_word_recognizer.sv
// Top level of the table-driven DFA word recognizer.
// Depends on dfa_pkg, dfa_ram and dfa_scan.
//
// Usage: issue a command by raising start while busy is low; the transfer
// happens on that rising edge. A rule load and a word end never raise busy.
// A word end is answered in the next cycle: done is high for exactly one
// cycle with result valid, and the receiver cannot hold it off, so capture it
// then. A symbol for a live word holds busy high while the rule table is
// scanned through its single read port, one entry per cycle: a symbol that
// matches at entry k stops the scan there, a symbol with no match scans all
// n entries where n = min(rule_count, MAX_RULES), a symbol with n = 0 is
// answered without a scan, and a symbol after the word has died is dropped
// without raising busy. The worst case is a scan of all n entries.
// Write configuration only while idle; start_state takes effect at the next
// word end. Rule table entries are undefined until loaded, so load every
// entry below rule_count before feeding symbols. There is no clearing pass.
module dfa_word_recognizer #(
	parameter int MAX_RULES  = 64,
	parameter int NUM_STATES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  dfa_pkg::cmd_t             cmd,
	output logic                      done,
	output dfa_pkg::result_t          result,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [dfa_pkg::CFG_W-1:0] cfg_data
);

	localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int CW = $clog2(MAX_RULES + 1);
	localparam int SW = (AW > 6) ? AW : 6;
	localparam int LW = (CW > 7) ? CW : 7;

	// configuration registers
	logic [dfa_pkg::STATE_W-1:0] start_state_q;
	logic [15:0]                 accept_mask_q;
	logic [6:0]                  rule_count_q;

	// word state
	logic [dfa_pkg::STATE_W-1:0] cur_q;
	logic                        dead_q;

	// result register
	logic                        done_q;
	dfa_pkg::result_t            result_q;

	logic                        take;
	logic                        scan_busy;
	logic                        ram_we;
	logic [SW-1:0]               slot_w;
	logic [LW-1:0]               rc_w;
	logic [CW-1:0]               limit;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [15:0]                 rd_raw;
	dfa_pkg::rule_t              rd_rule;
	dfa_pkg::rule_t              wr_rule;
	dfa_pkg::scan_req_t          req;
	dfa_pkg::scan_rsp_t          rsp;
	logic                        state_ok;

	assign busy = scan_busy;
	assign take = start && !scan_busy;

	// Rule loads: drop a slot beyond the table depth.
	always_comb begin
		slot_w             = SW'(cmd.rule_slot);
		wr_rule.from_state = cmd.rule_from;
		wr_rule.symbol     = cmd.rule_symbol;
		wr_rule.to_state   = cmd.rule_to;
		ram_we             = take && (cmd.op == dfa_pkg::OP_LOAD) &&
		                     ({26'd0, cmd.rule_slot} < 32'(MAX_RULES));
	end

	// Clamp the scan length to the table depth.
	always_comb begin
		rc_w  = LW'(rule_count_q);
		limit = (rc_w > LW'(MAX_RULES)) ? CW'(MAX_RULES) : CW'(rc_w);
	end

	// Launch a scan only for a live word; a dead word ignores further symbols.
	always_comb begin
		req.go         = take && (cmd.op == dfa_pkg::OP_SYMBOL) && !dead_q;
		req.symbol     = cmd.symbol;
		req.from_state = cur_q;
	end

	dfa_ram #(
		.WIDTH(16),
		.DEPTH(MAX_RULES)
	) u_rules (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_w[AW-1:0]),
		.wdata(wr_rule),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_raw)
	);

	assign rd_rule = rd_raw;

	dfa_scan #(
		.AW(AW),
		.CW(CW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.limit  (limit),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_rule),
		.rsp    (rsp),
		.busy   (scan_busy)
	);

	// States outside the configured range never accept.
	assign state_ok = ({28'd0, cur_q} < 32'(NUM_STATES)) && accept_mask_q[cur_q];

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q <= '0;
			accept_mask_q <= '0;
			rule_count_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				dfa_pkg::CFG_START_STATE: start_state_q <= cfg_data[dfa_pkg::STATE_W-1:0];
				dfa_pkg::CFG_ACCEPT_MASK: accept_mask_q <= cfg_data;
				dfa_pkg::CFG_RULE_COUNT:  rule_count_q  <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// Word state: advance on a scan response, report and restart on word end.
	// A word end is only taken while the scanner is idle, so the two never meet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			dead_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (rsp.done) begin
				if (rsp.hit) begin
					cur_q <= rsp.to_state;
				end else begin
					dead_q <= 1'b1;
				end
			end
			if (take && (cmd.op == dfa_pkg::OP_END)) begin
				done_q <= 1'b1;
				cur_q  <= start_state_q;
				dead_q <= 1'b0;
			end
		end
	end

	// Result payload: hold until the next word end.
	always_ff @(posedge clk) begin
		if (take && (cmd.op == dfa_pkg::OP_END)) begin
			result_q.accepted    <= !dead_q && state_ok;
			result_q.final_state <= cur_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: rtl/core/dfa_checker.sv
// Port-level checks for dfa_word_recognizer, attached by the bind below.
// Depends on dfa_pkg and on the ports of dfa_word_recognizer.
module dfa_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input dfa_pkg::cmd_t             cmd,
	input logic                      done,
	input logic                      cfg_we,
	input logic [1:0]                cfg_index,
	input logic [dfa_pkg::CFG_W-1:0] cfg_data
);

	logic end_take;
	logic load_take;
	logic sym_take;

	assign end_take  = start && !busy && (cmd.op == dfa_pkg::OP_END);
	assign load_take = start && !busy && (cmd.op == dfa_pkg::OP_LOAD);
	assign sym_take  = start && !busy && (cmd.op == dfa_pkg::OP_SYMBOL);

	a_end_answers: assert property (@(posedge clk) disable iff (!arst_n)
		end_take |=> done)
		else $error("word end transfer not answered in the next cycle");

	a_done_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(end_take))
		else $error("result strobe without a preceding word end");

	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		load_take |=> !busy)
		else $error("rule load held the block busy");

	a_busy_from_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(sym_take))
		else $error("busy rose without a symbol transfer");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> (!busy && !$isunknown({cfg_index, cfg_data})))
		else $error("configuration written while a symbol is in progress");

endmodule

bind dfa_word_recognizer dfa_checker u_dfa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.cmd      (cmd),
	.done     (done),
	.cfg_we   (cfg_we),
	.cfg_index(cfg_index),
	.cfg_data (cfg_data)
);

FILE: test/tb.sv
// Self-checking testbench for dfa_word_recognizer: loads rule tables, feeds words
// and checks each word-end verdict against a behavioural model kept in this file.
// Depends on dfa_pkg and the dfa_word_recognizer RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfa_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;   // unused op code, the block drops it
	localparam int TABLE_DEPTH = 64;
	localparam int SCAN_SETTLE = 72;          // longest symbol scan plus a margin
	localparam int STALL_LIMIT = 2000;        // cycles without any transfer

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	logic             busy;
	cmd_t             cmd;
	logic             done;
	result_t          result;
	logic             cfg_we;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// Behavioural copy of the recogniser: registers, word state and rule table.
	logic [STATE_W-1:0] m_start;
	logic [15:0]        m_accept;
	logic [6:0]         m_count;
	logic [STATE_W-1:0] m_state;
	logic               m_dead;
	rule_t              m_rules [TABLE_DEPTH];

	result_t          verdicts_due [$];    // word-end verdicts still to arrive
	logic [SYM_W-1:0] alphabet [8];        // small alphabet so that rules collide
	bit               gaps_on;
	int               errors = 0;
	int               stall_cycles = 0;

	dfa_word_recognizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Advance the model by one accepted command; a word end queues its verdict.
	function automatic void take_transfer(cmd_t c);
		int unsigned n;
		int unsigned k;
		bit          hit;
		result_t     v;
		n = (m_count > TABLE_DEPTH) ? TABLE_DEPTH : m_count;
		hit = 1'b0;
		case (c.op)
			OP_LOAD: begin
				m_rules[c.rule_slot] = {c.rule_from, c.rule_symbol, c.rule_to};
			end
			OP_SYMBOL: begin
				// first matching slot wins; no match kills the word where it stands
				if (!m_dead) begin
					for (k = 0; k < n && !hit; k++) begin
						if (m_rules[k].from_state == m_state &&
								m_rules[k].symbol == c.symbol) begin
							m_state = m_rules[k].to_state;
							hit = 1'b1;
						end
					end
					if (!hit)
						m_dead = 1'b1;
				end
			end
			OP_END: begin
				v.accepted = !m_dead && m_accept[m_state];
				v.final_state = m_state;
				verdicts_due.push_back(v);
				m_state = m_start;
				m_dead = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// Command builders: fields the op does not use carry random bits.
	function automatic cmd_t load_cmd(logic [5:0] slot, logic [STATE_W-1:0] from,
			logic [SYM_W-1:0] sym, logic [STATE_W-1:0] to);
		cmd_t c;
		c = $urandom();
		c.op = OP_LOAD;
		c.rule_slot = slot;
		c.rule_from = from;
		c.rule_symbol = sym;
		c.rule_to = to;
		return c;
	endfunction

	function automatic cmd_t sym_cmd(logic [SYM_W-1:0] sym);
		cmd_t c;
		c = $urandom();
		c.op = OP_SYMBOL;
		c.symbol = sym;
		return c;
	endfunction

	function automatic cmd_t op_cmd(logic [1:0] op);
		cmd_t c;
		c = $urandom();
		c.op = op;
		return c;
	endfunction

	function automatic cmd_t random_rule(logic [5:0] slot);
		logic [SYM_W-1:0] sym;
		sym = ($urandom_range(0, 7) == 0) ? SYM_W'($urandom()) : alphabet[$urandom_range(0, 7)];
		return load_cmd(slot, STATE_W'($urandom_range(0, 15)), sym,
				STATE_W'($urandom_range(0, 15)));
	endfunction

	// Pick a symbol that some live rule takes from the current state, so that
	// random words walk the automaton instead of dying on the first byte.
	function automatic logic [SYM_W-1:0] next_symbol();
		logic [SYM_W-1:0] opts [$];
		int unsigned      n;
		int unsigned      k;
		n = (m_count > TABLE_DEPTH) ? TABLE_DEPTH : m_count;
		for (k = 0; k < n; k++) begin
			if (m_rules[k].from_state == m_state)
				opts.push_back(m_rules[k].symbol);
		end
		if (opts.size() == 0)
			return alphabet[$urandom_range(0, 7)];
		return opts[$urandom_range(0, opts.size() - 1)];
	endfunction

	// Offer one command and hold it until the transfer; start stays high after.
	task automatic issue(cmd_t c);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		take_transfer(c);
	endtask

	task automatic await_verdicts();
		start <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
	endtask

	// Drain, let any scan finish, then write all three registers back to back.
	task automatic configure(logic [STATE_W-1:0] st, logic [15:0] mask, logic [6:0] count);
		await_verdicts();
		repeat (SCAN_SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_START_STATE;
		cfg_data <= CFG_W'(st);
		@(posedge clk);
		cfg_index <= CFG_ACCEPT_MASK;
		cfg_data <= mask;
		@(posedge clk);
		cfg_index <= CFG_RULE_COUNT;
		cfg_data <= CFG_W'(count);
		@(posedge clk);
		cfg_we <= 1'b0;
		m_start = st;
		m_accept = mask;
		m_count = count;
	endtask

	// With no valid rules every symbol kills the word.
	task automatic test_empty_table();
		issue(sym_cmd(8'h00));
		issue(op_cmd(OP_END));
	endtask

	// Four rules, the last one shadowed by slot 0; exercise match, first match,
	// a non-accepting end and the spare op.
	task automatic test_directed_rules();
		issue(load_cmd(6'd0, 4'd0, 8'h00, 4'd5));
		issue(load_cmd(6'd1, 4'd0, 8'hFF, 4'd15));
		issue(load_cmd(6'd2, 4'd15, 8'h55, 4'd10));
		issue(load_cmd(6'd3, 4'd0, 8'h00, 4'd3));
		issue(op_cmd(OP_SPARE));
		configure(4'd0, 16'h8000, 7'd4);
		issue(sym_cmd(8'hFF));
		issue(op_cmd(OP_END));
		issue(sym_cmd(8'h00));
		issue(op_cmd(OP_END));
		issue(sym_cmd(8'hFF));
		issue(sym_cmd(8'h55));
		issue(op_cmd(OP_END));
	endtask

	// A dead word is rejected even in an accepting state; later symbols are dropped.
	task automatic test_dead_word();
		configure(4'd0, 16'hFFFF, 7'd4);
		issue(sym_cmd(8'h00));
		issue(sym_cmd(8'h77));
		issue(sym_cmd(8'h00));
		issue(op_cmd(OP_END));
	endtask

	// A new start state must leave the word in flight alone.
	task automatic test_start_change();
		issue(sym_cmd(8'hFF));
		configure(4'd15, 16'hFFFF, 7'd4);
		issue(sym_cmd(8'h55));
		issue(op_cmd(OP_END));
		issue(sym_cmd(8'h55));
		issue(op_cmd(OP_END));
	endtask

	// Load every slot so that any rule count can be scanned safely.
	task automatic test_fill_table();
		int unsigned s;
		alphabet[0] = 8'h00;
		alphabet[1] = 8'hFF;
		for (s = 2; s < 8; s++)
			alphabet[s] = SYM_W'($urandom());
		for (s = 0; s < TABLE_DEPTH; s++)
			issue(random_rule(6'(s)));
	endtask

	// Mostly walked words, with random bytes, spare ops and rule reloads mixed in.
	task automatic test_random_words(logic [STATE_W-1:0] st, logic [15:0] mask,
			logic [6:0] count, int items);
		int sent;
		int pick;
		configure(st, mask, count);
		sent = 0;
		while (sent < items) begin
			if (gaps_on && $urandom_range(0, 24) == 0)
				await_verdicts();
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				issue(op_cmd(OP_END));
			end else if (pick < 16) begin
				issue(sym_cmd(SYM_W'($urandom())));
			end else if (pick < 19) begin
				issue(op_cmd(OP_SPARE));
				sent--;
			end else if (pick < 23) begin
				issue(random_rule(6'($urandom_range(0, TABLE_DEPTH - 1))));
			end else begin
				issue(sym_cmd(next_symbol()));
			end
			sent++;
		end
		issue(op_cmd(OP_END));
	endtask

	// Check each verdict against the oldest expectation.
	always @(posedge clk) begin : check_verdicts
		result_t want;
		if (arst_n && done) begin
			if (verdicts_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected verdict accepted=%0b final_state=%0d",
						$time, result.accepted, result.final_state);
			end else begin
				want = verdicts_due.pop_front();
				if (result.accepted !== want.accepted) begin
					errors++;
					$display("%0t: accepted expected %0b got %0b",
							$time, want.accepted, result.accepted);
				end
				if (result.final_state !== want.final_state) begin
					errors++;
					$display("%0t: final_state expected %0d got %0d",
							$time, want.final_state, result.final_state);
				end
			end
		end
	end

	// Drop the run if no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("%0t: watchdog, no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_START_STATE;
		cfg_data = '0;
		m_start = '0;
		m_accept = '0;
		m_count = '0;
		m_state = '0;
		m_dead = 1'b0;
		foreach (m_rules[i])
			m_rules[i] = '0;
		gaps_on = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_directed_rules();
		test_dead_word();
		test_start_change();
		test_fill_table();
		test_random_words(4'd0, 16'h0000, 7'd64, 70);
		test_random_words(4'd15, 16'hFFFF, 7'd127, 80);
		test_random_words(STATE_W'($urandom_range(0, 15)), 16'($urandom()), 7'd1, 60);
		test_random_words(STATE_W'($urandom_range(0, 15)), 16'($urandom()),
				7'($urandom_range(1, 64)), 80);
		test_random_words(STATE_W'($urandom_range(0, 15)), 16'($urandom()), 7'd0, 30);
		gaps_on = 1'b0;
		test_random_words(STATE_W'($urandom_range(0, 15)), 16'($urandom()), 7'd64, 90);

		await_verdicts();
		repeat (SCAN_SETTLE) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
